>>> sv/u8bt_pkg.sv
package u8bt_pkg;

   localparam int MaxCharBytes = 4;
   localparam int MaxTokens = 4;
   localparam int CountW = $clog2(MaxTokens + 1);

   localparam logic [7:0] ContMask = 8'hC0;
   localparam logic [7:0] ContTag = 8'h80;

   typedef enum logic {
      KIND_UNIGRAM = 1'b0,
      KIND_BIGRAM = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type kind;
      logic [63:0] bytes;
      logic [3:0] length;
      logic truncated;
      logic run_end;
      logic text_end;
   } tok_type;

   typedef struct packed {
      logic [31:0] cur_char;
      logic [2:0] cur_len;
      logic [31:0] prev_char;
      logic [2:0] prev_len;
      logic [1:0] cut;
   } state_type;

   typedef struct packed {
      tok_type uni;
      tok_type bi;
      logic bi_valid;
      state_type next;
   } close_type;

   typedef struct packed {
      tok_type [MaxTokens-1:0] toks;
      logic [CountW-1:0] count;
   } bundle_type;

   // Closes the current character: unigram, optional bigram, and the state after.
   function automatic close_type close_char(state_type st, logic overlap);
      close_type res;
      logic [63:0] pair;
      res = '0;
      case (st.prev_len)
         3'd1: pair = {24'd0, st.cur_char, st.prev_char[7:0]};
         3'd2: pair = {16'd0, st.cur_char, st.prev_char[15:0]};
         3'd3: pair = {8'd0, st.cur_char, st.prev_char[23:0]};
         default: pair = {st.cur_char, st.prev_char};
      endcase
      res.uni.kind = KIND_UNIGRAM;
      res.uni.bytes = {32'd0, st.cur_char};
      res.uni.length = {1'b0, st.cur_len};
      res.uni.truncated = st.cut[0];
      res.bi.kind = KIND_BIGRAM;
      res.bi.bytes = pair;
      res.bi.length = {1'b0, st.prev_len} + {1'b0, st.cur_len};
      res.bi.truncated = (st.cut != 2'd0);
      res.bi_valid = (st.prev_len != 3'd0);
      res.next = '0;
      if (!(res.bi_valid && !overlap)) begin
         res.next.prev_char = st.cur_char;
         res.next.prev_len = st.cur_len;
         res.next.cut = {st.cut[0], 1'b0};
      end
      return res;
   endfunction

endpackage

>>> sv/u8bt_req_if.sv
interface u8bt_req_if;
   logic valid;
   logic ready;
   logic [7:0] text_byte;
   logic end_of_text;

   modport source(output valid, text_byte, end_of_text, input ready);
   modport sink(input valid, text_byte, end_of_text, output ready);
endinterface

>>> sv/u8bt_rsp_if.sv
interface u8bt_rsp_if;
   logic valid;
   logic ready;
   logic token_kind;
   logic [63:0] token_bytes;
   logic [3:0] token_length;
   logic truncated;
   logic run_end;
   logic text_end;

   modport source(output valid, token_kind, token_bytes, token_length, truncated,
      run_end, text_end, input ready);
   modport sink(input valid, token_kind, token_bytes, token_length, truncated,
      run_end, text_end, output ready);
endinterface

>>> sv/u8bt_csr_if.sv
interface u8bt_csr_if;
   logic valid;
   logic ready;
   logic overlap_mode;

   modport source(output valid, overlap_mode, input ready);
   modport sink(input valid, overlap_mode, output ready);
endinterface

>>> sv/u8bt_tokenize.sv
module u8bt_tokenize import u8bt_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic overlap_mode,
   input  logic in_valid,
   output logic in_ready,
   input  logic [7:0] in_byte,
   input  logic in_eot,
   input  logic load_ok,
   output logic bundle_valid,
   output bundle_type bundle
);

   logic valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic eot_ff;
   state_type state_ff, state_in;

   close_type first_close;
   close_type flush_close;
   state_type mid;
   tok_type [MaxTokens-1:0] cand;
   logic [MaxTokens-1:0] cand_valid;
   logic consume;
   logic [CountW-1:0] n;
   logic [4:0] lane;

   always_comb begin
      first_close = close_char(state_ff, overlap_mode);
      mid = state_ff;
      if ((byte_ff & ContMask) != ContTag && state_ff.cur_len != 3'd0) begin
         mid = first_close.next;
      end
      lane = {mid.cur_len[1:0], 3'b000};
      if (mid.cur_len < 3'(MaxCharBytes)) begin
         mid.cur_char[lane +: 8] = mid.cur_char[lane +: 8] | byte_ff;
         mid.cur_len = mid.cur_len + 3'd1;
      end else begin
         mid.cut[0] = 1'b1;
      end
      flush_close = close_char(mid, overlap_mode);

      cand = {flush_close.bi, flush_close.uni, first_close.bi, first_close.uni};
      cand_valid[0] = (byte_ff & ContMask) != ContTag && state_ff.cur_len != 3'd0;
      cand_valid[1] = cand_valid[0] && first_close.bi_valid;
      cand_valid[2] = eot_ff;
      cand_valid[3] = eot_ff && flush_close.bi_valid;

      bundle = '0;
      n = '0;
      for (int i = 0; i < MaxTokens; i++) begin
         if (cand_valid[i]) begin
            bundle.toks[n[CountW-2:0]] = cand[i];
            n = n + CountW'(1);
         end
      end
      bundle.count = n;
      if (n != '0) begin
         bundle.toks[n[CountW-2:0] - 2'd1].run_end = 1'b1;
         bundle.toks[n[CountW-2:0] - 2'd1].text_end = eot_ff;
      end

      bundle_valid = valid_ff && (n != '0);
      consume = valid_ff && (n == '0 || load_ok);
      in_ready = !valid_ff || consume;
      valid_in = in_valid || (valid_ff && !consume);

      state_in = state_ff;
      if (consume) begin
         state_in = eot_ff ? state_type'('0) : mid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         state_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         byte_ff <= in_byte;
         eot_ff <= in_eot;
      end
   end

endmodule

>>> sv/u8bt_out_queue.sv
module u8bt_out_queue import u8bt_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic bundle_valid,
   input  bundle_type bundle,
   output logic load_ok,
   output logic out_valid,
   input  logic out_ready,
   output tok_type out_tok
);

   tok_type [MaxTokens-1:0] slots_ff, slots_in;
   logic [CountW-1:0] count_ff, count_in;
   logic take;

   always_comb begin
      out_valid = (count_ff != '0);
      out_tok = slots_ff[0];
      take = out_valid && out_ready;
      load_ok = (count_ff == '0) || (count_ff == CountW'(1) && out_ready);
      slots_in = slots_ff;
      count_in = count_ff;
      if (bundle_valid && load_ok) begin
         slots_in = bundle.toks;
         count_in = bundle.count;
      end else if (take) begin
         for (int i = 0; i < MaxTokens - 1; i++) begin
            slots_in[i] = slots_ff[i + 1];
         end
         count_in = count_ff - CountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slots_ff <= slots_in;
   end

endmodule

>>> sv/utf8_bigram_tokenizer.sv
// Splits a UTF-8 byte stream into characters and emits, for each closed
// character, a unigram word and, when a previous character is held, a bigram
// word; the end-of-text byte flushes the final character and clears the state.
// A byte is registered on entry, and its words are formed from the registered
// byte and loaded into a four-word result buffer that drains one word per
// cycle while the receiver is ready. A byte makes up to four words; the buffer
// takes a byte's words only when it is empty or its last word is being taken,
// so the input stalls while earlier words drain.
// The mode register may be written only while no byte is in flight.
module utf8_bigram_tokenizer import u8bt_pkg::*; (
   input logic clock,
   input logic reset,
   u8bt_req_if.sink req_if,
   u8bt_rsp_if.source rsp_if,
   u8bt_csr_if.sink csr_if
);

   logic overlap_mode_ff, overlap_mode_in;
   logic load_ok;
   logic bundle_valid;
   bundle_type bundle;
   tok_type out_tok;

   assign csr_if.ready = 1'b1;
   assign overlap_mode_in = csr_if.valid ? csr_if.overlap_mode : overlap_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         overlap_mode_ff <= 1'b1;
      end else begin
         overlap_mode_ff <= overlap_mode_in;
      end
   end

   u8bt_tokenize u_tokenize (
      .clock(clock),
      .reset(reset),
      .overlap_mode(overlap_mode_ff),
      .in_valid(req_if.valid),
      .in_ready(req_if.ready),
      .in_byte(req_if.text_byte),
      .in_eot(req_if.end_of_text),
      .load_ok(load_ok),
      .bundle_valid(bundle_valid),
      .bundle(bundle)
   );

   u8bt_out_queue u_out_queue (
      .clock(clock),
      .reset(reset),
      .bundle_valid(bundle_valid),
      .bundle(bundle),
      .load_ok(load_ok),
      .out_valid(rsp_if.valid),
      .out_ready(rsp_if.ready),
      .out_tok(out_tok)
   );

   assign rsp_if.token_kind = out_tok.kind;
   assign rsp_if.token_bytes = out_tok.bytes;
   assign rsp_if.token_length = out_tok.length;
   assign rsp_if.truncated = out_tok.truncated;
   assign rsp_if.run_end = out_tok.run_end;
   assign rsp_if.text_end = out_tok.text_end;

endmodule

>>> sv/u8bt_checker.sv
module u8bt_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic token_kind,
   input logic [63:0] token_bytes,
   input logic [3:0] token_length,
   input logic run_end,
   input logic text_end
);

   // The output is empty in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   a_text_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && text_end |-> run_end)
      else $error("text end without run end");

   a_unigram_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !token_kind |-> token_length != 4'd0 && token_length <= 4'd4
         && token_bytes[63:32] == 32'd0)
      else $error("bad unigram word");

   a_bigram_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && token_kind |-> token_length >= 4'd2 && token_length <= 4'd8)
      else $error("bad bigram length");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(token_bytes)
         && $stable(token_length) && $stable(run_end))
      else $error("stalled result word changed");

endmodule

bind utf8_bigram_tokenizer u8bt_checker u_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_if.valid),
   .rsp_ready(rsp_if.ready),
   .token_kind(rsp_if.token_kind),
   .token_bytes(rsp_if.token_bytes),
   .token_length(rsp_if.token_length),
   .run_end(rsp_if.run_end),
   .text_end(rsp_if.text_end)
);

>>> dv/tb_utf8_bigram_tokenizer.sv
`timescale 1ns / 1ps

module tb_utf8_bigram_tokenizer;
   import u8bt_pkg::*;

   typedef struct packed {
      logic [7:0] text_byte;
      logic end_of_text;
   } text_item_type;

   localparam int IdlePct = 14;
   localparam int DrainCycles = 6;
   localparam int HoldCycles = 80;
   localparam int HoldAtByte = 200;
   localparam int CalmFrom = 300;
   localparam int CalmTo = 380;
   localparam int PhaseBytes = 110;
   localparam int MaxReports = 10;

   logic clock;
   logic reset;

   u8bt_req_if req_if();
   u8bt_rsp_if rsp_if();
   u8bt_csr_if csr_if();

   utf8_bigram_tokenizer u_top (
      .clock(clock),
      .reset(reset),
      .req_if(req_if),
      .rsp_if(rsp_if),
      .csr_if(csr_if)
   );

   logic overlap_cfg;
   logic [31:0] cur_char;
   logic [2:0] cur_len;
   logic [31:0] prev_char;
   logic [2:0] prev_len;
   logic [1:0] cut_flags;

   text_item_type text_queue[$];
   tok_type step_tokens[$];
   tok_type pending_tokens[$];
   int errors = 0;
   int bytes_accepted;
   int hold_left;
   bit hold_fired;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic bit calm_window();
      return bytes_accepted >= CalmFrom && bytes_accepted < CalmTo;
   endfunction

   task automatic close_char_tokens();
      tok_type tok;
      tok = '0;
      tok.kind = KIND_UNIGRAM;
      tok.bytes = {32'd0, cur_char};
      tok.length = {1'b0, cur_len};
      tok.truncated = cut_flags[0];
      step_tokens.insert(step_tokens.size(), tok);
      if (prev_len != 3'd0) begin
         tok.kind = KIND_BIGRAM;
         tok.bytes = {32'd0, prev_char} | ({32'd0, cur_char} << (8 * prev_len));
         tok.length = {1'b0, prev_len} + {1'b0, cur_len};
         tok.truncated = (cut_flags != 2'd0);
         step_tokens.insert(step_tokens.size(), tok);
      end
      if (prev_len != 3'd0 && !overlap_cfg) begin
         prev_char = '0;
         prev_len = '0;
         cut_flags = '0;
      end else begin
         prev_char = cur_char;
         prev_len = cur_len;
         cut_flags = {cut_flags[0], 1'b0};
      end
      cur_char = '0;
      cur_len = '0;
   endtask

   task automatic tokenize_byte(input logic [7:0] text_byte, input logic end_of_text);
      tok_type tok;
      step_tokens.delete();
      if ((text_byte & ContMask) != ContTag && cur_len != 3'd0) close_char_tokens();
      if (cur_len < MaxCharBytes) begin
         cur_char = cur_char | ({24'd0, text_byte} << (8 * cur_len[1:0]));
         cur_len = cur_len + 3'd1;
      end else begin
         cut_flags[0] = 1'b1;
      end
      if (end_of_text) begin
         close_char_tokens();
         prev_char = '0;
         prev_len = '0;
         cut_flags = '0;
      end
      if (step_tokens.size() != 0) begin
         tok = step_tokens.pop_back();
         tok.run_end = 1'b1;
         tok.text_end = end_of_text;
         step_tokens.insert(step_tokens.size(), tok);
      end
      foreach (step_tokens[i]) pending_tokens.insert(pending_tokens.size(), step_tokens[i]);
   endtask

   always @(posedge clock) begin : req_driver
      text_item_type item;
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.text_byte <= '0;
         req_if.end_of_text <= 1'b0;
         bytes_accepted <= 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            tokenize_byte(req_if.text_byte, req_if.end_of_text);
            bytes_accepted <= bytes_accepted + 1;
         end
         if (!req_if.valid || req_if.ready) begin
            if (text_queue.size() != 0 && (calm_window() || $urandom_range(99) >= IdlePct)) begin
               item = text_queue.pop_front();
               req_if.valid <= 1'b1;
               req_if.text_byte <= item.text_byte;
               req_if.end_of_text <= item.end_of_text;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // A single long hold-off lets the result buffer fill so that the input stalls.
   always @(posedge clock) begin : rsp_throttle
      if (reset) begin
         rsp_if.ready <= 1'b0;
         hold_left <= 0;
         hold_fired <= 1'b0;
      end else if (!hold_fired && bytes_accepted >= HoldAtByte) begin
         hold_fired <= 1'b1;
         hold_left <= HoldCycles;
         rsp_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= calm_window() || $urandom_range(99) >= IdlePct;
      end
   end

   always @(posedge clock) begin : token_monitor
      tok_type want;
      tok_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.kind = kind_type'(rsp_if.token_kind);
         got.bytes = rsp_if.token_bytes;
         got.length = rsp_if.token_length;
         got.truncated = rsp_if.truncated;
         got.run_end = rsp_if.run_end;
         got.text_end = rsp_if.text_end;
         if (pending_tokens.size() == 0) begin
            if (errors < MaxReports)
               $display("unexpected word: kind %0d bytes %h length %0d", got.kind,
                  got.bytes, got.length);
            errors++;
         end else begin
            want = pending_tokens.pop_front();
            if (got.kind != want.kind || got.bytes != want.bytes ||
                got.length != want.length || got.truncated != want.truncated ||
                got.run_end != want.run_end || got.text_end != want.text_end) begin
               if (errors < MaxReports) begin
                  $display("expected kind %0d bytes %h len %0d cut %0d run %0d text %0d",
                     want.kind, want.bytes, want.length, want.truncated, want.run_end,
                     want.text_end);
                  $display("     got kind %0d bytes %h len %0d cut %0d run %0d text %0d",
                     got.kind, got.bytes, got.length, got.truncated, got.run_end,
                     got.text_end);
               end
               errors++;
            end
         end
      end
   end

   task automatic push_byte(input logic [7:0] text_byte, input logic end_of_text);
      text_item_type item;
      item.text_byte = text_byte;
      item.end_of_text = end_of_text;
      text_queue.insert(text_queue.size(), item);
   endtask

   task automatic add_char(input bit force_end);
      int pick;
      int ncont;
      logic [31:0] rnd;
      logic [7:0] lead;
      bit eot_here;
      pick = $urandom_range(99);
      rnd = $urandom;
      if (pick < 30) begin
         lead = {1'b0, rnd[6:0]};
         ncont = 0;
      end else if (pick < 50) begin
         lead = {3'b110, rnd[4:0]};
         ncont = 1;
      end else if (pick < 65) begin
         lead = {4'b1110, rnd[3:0]};
         ncont = 2;
      end else if (pick < 78) begin
         lead = {5'b11110, rnd[2:0]};
         ncont = 3;
      end else if (pick < 86) begin
         lead = {5'b11111, rnd[2:0]};
         ncont = $urandom_range(4, 6);
      end else if (pick < 93) begin
         lead = {2'b10, rnd[5:0]};
         ncont = 0;
      end else begin
         lead = rnd[7:0];
         ncont = $urandom_range(0, 2);
      end
      eot_here = force_end || $urandom_range(99) < 8;
      push_byte(lead, eot_here && ncont == 0);
      for (int i = 0; i < ncont; i++) begin
         rnd = $urandom;
         push_byte({2'b10, rnd[5:0]}, eot_here && i == ncont - 1);
      end
   endtask

   task automatic wait_drained();
      while (text_queue.size() != 0 || req_if.valid || pending_tokens.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_mode(input logic mode);
      wait_drained();
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.overlap_mode <= mode;
      do @(posedge clock); while (!csr_if.ready);
      overlap_cfg = mode;
      csr_if.valid <= 1'b0;
   endtask

   initial begin : stimulus
      reset <= 1'b1;
      csr_if.valid <= 1'b0;
      csr_if.overlap_mode <= 1'b1;
      overlap_cfg = 1'b1;
      cur_char = '0;
      cur_len = '0;
      prev_char = '0;
      prev_len = '0;
      cut_flags = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      write_mode(1'b1);
      push_byte(8'h00, 1'b1);
      push_byte(8'h41, 1'b0);
      push_byte(8'hC3, 1'b0);
      push_byte(8'hA9, 1'b0);
      push_byte(8'hE2, 1'b0);
      push_byte(8'h82, 1'b0);
      push_byte(8'hAC, 1'b0);
      push_byte(8'hF0, 1'b0);
      push_byte(8'h9F, 1'b0);
      push_byte(8'h98, 1'b0);
      push_byte(8'h80, 1'b0);
      push_byte(8'hF8, 1'b0);
      for (int i = 0; i < 5; i++) push_byte(8'h80, 1'b0);
      push_byte(8'h41, 1'b1);
      push_byte(8'h80, 1'b0);
      push_byte(8'h7F, 1'b1);
      push_byte(8'hFF, 1'b1);

      write_mode(1'b0);
      push_byte(8'h41, 1'b0);
      push_byte(8'h42, 1'b0);
      push_byte(8'h43, 1'b0);
      push_byte(8'h44, 1'b0);
      push_byte(8'hC3, 1'b0);
      push_byte(8'hA9, 1'b1);

      // Even phases stop inside a text, so the next mode applies mid-text.
      for (int phase = 0; phase < 4; phase++) begin
         write_mode(phase % 2 == 0);
         while (text_queue.size() < PhaseBytes) add_char(1'b0);
         if (phase % 2 == 1) add_char(1'b1);
      end

      wait_drained();
      if (errors == 0 && pending_tokens.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
